// ===== src/rtb_pkg.sv =====
// rtb_pkg: shared types and constants for the retransmit timer backoff block
// used by the channel interfaces, the top level and the checker

package rtb_pkg;

    localparam int unsigned DUR_W   = 31;
    localparam int unsigned ARM_W   = 32;
    localparam int unsigned GEN_W   = 32;
    localparam int unsigned TID_W   = 32;
    localparam int unsigned LIM_W   = 17;
    localparam int unsigned CNT_W   = 16;
    localparam int unsigned CFG_IW  = 2;
    localparam int unsigned CFG_DW  = 32;

    localparam logic [DUR_W-1:0] RST_DURATION = DUR_W'(1000);
    localparam logic [LIM_W-1:0] RST_LIMIT    = {LIM_W{1'b1}};
    localparam logic [TID_W-1:0] RST_TIMER_ID = TID_W'(1);

    typedef enum logic [CFG_IW-1:0] {
        REG_BASE_DURATION = 2'd0,
        REG_MAX_RESTARTS  = 2'd1,
        REG_BACKOFF_EXP   = 2'd2,
        REG_TIMER_ID      = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        CMD_START   = 2'd0,
        CMD_STOP    = 2'd1,
        CMD_RESTART = 2'd2,
        CMD_EXPIRY  = 2'd3
    } t_command;

    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_ARM   = 2'd1,
        ACT_STOP  = 2'd2,
        ACT_REARM = 2'd3
    } t_action;

    typedef struct packed {
        t_command          command;
        logic [GEN_W-1:0]  expired_generation;
        logic              new_duration_valid;
        logic [DUR_W-1:0]  new_dur_ms;
    } t_cmd_word;

    typedef struct packed {
        t_action                 action;
        logic [ARM_W-1:0]        arm_duration_ms;
        logic [TID_W+GEN_W-1:0]  arm_id;
        logic                    expired_notice;
        logic                    running;
        logic [CNT_W-1:0]        expiry_count;
    } t_res_word;

endpackage

// ===== src/rtb_cmd_if.sv =====
// rtb_cmd_if: valid/ready channel carrying one command word
// depends on rtb_pkg

interface rtb_cmd_if;
    import rtb_pkg::*;

    logic      valid;
    logic      ready;
    t_cmd_word word;

    modport source (output valid, output word, input ready);
    modport sink   (input valid, input word, output ready);
endinterface

// ===== src/rtb_res_if.sv =====
// rtb_res_if: valid/ready channel carrying one result word
// depends on rtb_pkg

interface rtb_res_if;
    import rtb_pkg::*;

    logic      valid;
    logic      ready;
    t_res_word word;

    modport source (output valid, output word, input ready);
    modport sink   (input valid, input word, output ready);
endinterface

// ===== src/retransmit_timer_backoff.sv =====
// retransmit_timer_backoff: retransmission timer control with optional exponential backoff
// depends on rtb_pkg, rtb_cmd_if, rtb_res_if
//
// channel    dir  handshake     word
// i_cmd_if   in   valid/ready   command, expired_generation, new_duration_valid/_ms
// o_res_if   out  valid/ready   action, arm_duration_ms, arm_id, notice, running, count
// i_cfg_*    in   write enable  register index, 32-bit data
//
// one word per cycle sustained while the result channel is not stalled
// a command word is registered, then decoded combinationally against the timer state,
// and the state and result register are updated together
// reset is synchronous; it clears timer state and loads register defaults
// while the result waits, the command register holds one more word, then ready drops

module retransmit_timer_backoff (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [rtb_pkg::CFG_IW-1:0] i_cfg_idx,
    input  logic [rtb_pkg::CFG_DW-1:0] i_cfg_data,
    rtb_cmd_if.sink                   i_cmd_if,
    rtb_res_if.source                 o_res_if
);
    import rtb_pkg::*;

    function automatic logic [ARM_W-1:0] f_backoff(
        input logic [DUR_W-1:0] base,
        input logic [LIM_W-1:0] wide,
        input logic             expo
    );
        logic [DUR_W+ARM_W-1:0] shifted;
        logic [ARM_W-1:0]       res;
        shifted = {{ARM_W{1'b0}}, base} << wide[4:0];
        if (!expo || base == '0) begin
            res = {1'b0, base};
        end else if (wide[LIM_W-1:5] != '0) begin
            res = '1;
        end else if (shifted[DUR_W+ARM_W-1:ARM_W] != '0) begin
            res = '1;
        end else begin
            res = shifted[ARM_W-1:0];
        end
        return res;
    endfunction

    // configuration
    logic [LIM_W-1:0] r_limit;
    logic             r_expo;
    logic [TID_W-1:0] r_tid;

    // timer state
    logic             r_active, n_active;
    logic [GEN_W-1:0] r_gen, n_gen;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [DUR_W-1:0] r_cur, n_cur;

    // command register and result register
    logic             r_in_vld;
    t_cmd_word        r_in;
    logic             r_out_vld;
    t_res_word        r_out, n_out;

    logic             adv;
    logic [GEN_W-1:0] gen_inc;
    logic [LIM_W-1:0] wide;
    logic             over_limit;

    assign adv     = r_in_vld && (!r_out_vld || o_res_if.ready);
    assign gen_inc = r_gen + GEN_W'(1);
    assign wide    = {1'b0, r_cnt} + LIM_W'(1);
    assign over_limit = !r_limit[LIM_W-1] && (wide > {1'b0, r_limit[CNT_W-1:0]});

    assign i_cmd_if.ready = !r_in_vld || adv;
    assign o_res_if.valid = r_out_vld;
    assign o_res_if.word  = r_out;

    always_comb begin
        n_active = r_active;
        n_gen    = r_gen;
        n_cnt    = r_cnt;
        n_cur    = r_cur;
        n_out    = '0;
        n_out.action = ACT_NONE;
        case (r_in.command)
            CMD_START: begin
                if (!r_active) begin
                    n_active = 1'b1;
                    n_cnt    = '0;
                    n_gen    = gen_inc;
                    n_out.action          = ACT_ARM;
                    n_out.arm_duration_ms = {1'b0, r_cur};
                    n_out.arm_id          = {r_tid, gen_inc};
                end
            end
            CMD_STOP: begin
                if (r_active) begin
                    n_active     = 1'b0;
                    n_cnt        = '0;
                    n_out.action = ACT_STOP;
                end
            end
            CMD_RESTART: begin
                n_active = 1'b1;
                n_cnt    = '0;
                n_gen    = gen_inc;
                n_out.action          = r_active ? ACT_REARM : ACT_ARM;
                n_out.arm_duration_ms = {1'b0, r_cur};
                n_out.arm_id          = {r_tid, gen_inc};
            end
            CMD_EXPIRY: begin
                if (r_active && r_in.expired_generation == r_gen) begin
                    n_out.expired_notice = 1'b1;
                    n_cnt = wide[LIM_W-1] ? '1 : wide[CNT_W-1:0];
                    if (r_in.new_duration_valid) begin
                        n_cur = r_in.new_dur_ms;
                    end
                    if (over_limit) begin
                        n_active = 1'b0;
                    end else begin
                        n_gen = gen_inc;
                        n_out.action          = ACT_ARM;
                        n_out.arm_duration_ms = f_backoff(n_cur, wide, r_expo);
                        n_out.arm_id          = {r_tid, gen_inc};
                    end
                end
            end
            default: begin
                n_out.action = ACT_NONE;
            end
        endcase
        n_out.running      = n_active;
        n_out.expiry_count = n_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit   <= RST_LIMIT;
            r_expo    <= 1'b0;
            r_tid     <= RST_TIMER_ID;
            r_active  <= 1'b0;
            r_gen     <= '0;
            r_cnt     <= '0;
            r_cur     <= RST_DURATION;
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cmd_if.valid && i_cmd_if.ready) begin
                r_in_vld <= 1'b1;
            end else if (adv) begin
                r_in_vld <= 1'b0;
            end
            if (adv) begin
                r_out_vld <= 1'b1;
                r_active  <= n_active;
                r_gen     <= n_gen;
                r_cnt     <= n_cnt;
                r_cur     <= n_cur;
            end else if (o_res_if.ready) begin
                r_out_vld <= 1'b0;
            end
            if (i_cfg_we) begin
                case (t_reg_idx'(i_cfg_idx))
                    REG_BASE_DURATION: begin
                        r_cur  <= i_cfg_data[DUR_W-1:0];
                    end
                    REG_MAX_RESTARTS: r_limit <= i_cfg_data[LIM_W-1:0];
                    REG_BACKOFF_EXP:  r_expo  <= i_cfg_data[0];
                    REG_TIMER_ID:     r_tid   <= i_cfg_data[TID_W-1:0];
                    default: begin
                        r_expo <= r_expo;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd_if.valid && i_cmd_if.ready) begin
            r_in <= i_cmd_if.word;
        end
        if (adv) begin
            r_out <= n_out;
        end
    end

endmodule

// ===== src/rtb_checker.sv =====
// rtb_checker: port-level checks on the retransmit timer result channel
// depends on rtb_pkg; bound to retransmit_timer_backoff

module rtb_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_res_valid,
    input logic               i_res_ready,
    input rtb_pkg::t_res_word i_res_word
);
    import rtb_pkg::*;

    // no arm request carries no duration and no id
    a_no_arm_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && (i_res_word.action == ACT_NONE || i_res_word.action == ACT_STOP)
        |-> i_res_word.arm_duration_ms == '0 && i_res_word.arm_id == '0)
        else $error("no-arm result carries duration or id");

    // any arm leaves the timer running
    a_arm_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && (i_res_word.action == ACT_ARM || i_res_word.action == ACT_REARM)
        |-> i_res_word.running)
        else $error("arm result with timer not running");

    // stop clears running and the count
    a_stop_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res_word.action == ACT_STOP
        |-> !i_res_word.running && i_res_word.expiry_count == '0)
        else $error("stop result with running timer or nonzero count");

    // an accepted expiry without re-arm means the limit stopped the timer
    a_expiry_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res_word.expired_notice && i_res_word.action == ACT_NONE
        |-> !i_res_word.running && i_res_word.expiry_count != '0)
        else $error("expiry without re-arm while still running");

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_res_word))
        else $error("stalled result word changed");

endmodule

bind retransmit_timer_backoff rtb_checker u_rtb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_res_valid (o_res_if.valid),
    .i_res_ready (o_res_if.ready),
    .i_res_word  (o_res_if.word)
);
